@@ src/rpid_pkg.sv @@
package rpid_pkg;

    // Field and register widths.
    localparam int AXIS_W    = 2;
    localparam int RATE_W    = 32;
    localparam int DT_W      = 24;
    localparam int LANE_W    = 16;
    localparam int NUM_LANES = 3;
    localparam int CREG_W    = LANE_W * NUM_LANES;
    localparam int CIDX_W    = 3;

    // Internal arithmetic widths.
    localparam int ERR_W      = RATE_W + 1;         // setpoint minus measurement
    localparam int MAG_W      = 19;                 // error magnitude below the rate limit
    localparam int MAG_SQ_W   = 2 * MAG_W;
    localparam int FAC_FRAC_W = 16;                 // fraction bits of the integral factor
    localparam int QUO_W      = FAC_FRAC_W + 1;     // square-law quotient and its estimate
    localparam int INTEG_W    = 21;                 // |integrator| <= 16 * (2^16 - 1)
    localparam int UPD_W      = 25;                 // integrator plus one increment
    localparam int MUL_A_W    = ERR_W;
    localparam int MUL_B_W    = DT_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = 52;                 // torque accumulator, Q.28
    localparam int TRQ_SH     = 12;
    localparam int SCALE_W    = 24;                 // increment chain operand
    localparam int RND_IN_W   = 49;

    // Reciprocal division of the squared error by the squared rate limit.
    localparam int SQ_DROP    = 6;                  // low bits of the square left out
    localparam int RECIP_SH   = 39;                 // shift after the reciprocal product
    localparam int SQ_SPLIT   = 16;                 // split point of the squared limit
    localparam int QCMP_W     = 56;                 // quotient times the squared limit
    localparam int QHI_W      = QCMP_W - SQ_SPLIT;

    // radians(400) in Q16.16 and its square.
    localparam logic [ERR_W-1:0]    RATE_LIMIT    = 33'd457528;
    localparam logic [MAG_SQ_W-1:0] RATE_LIMIT_SQ = 38'd209331870784;

    // floor(2^61 / RATE_LIMIT_SQ): with the square shifted down by SQ_DROP and
    // the product shifted down by RECIP_SH, the estimate is at most one low.
    localparam logic [MUL_B_W-1:0] RATE_LIMIT_SQ_RECIP = 24'd11015250;
    // The squared limit in two pieces that each fit the shared multiplier.
    localparam logic [MUL_B_W-1:0] RATE_LIMIT_SQ_HI = MUL_B_W'(RATE_LIMIT_SQ >> SQ_SPLIT);
    localparam logic [MUL_B_W-1:0] RATE_LIMIT_SQ_LO = MUL_B_W'(RATE_LIMIT_SQ[SQ_SPLIT-1:0]);

    typedef logic [AXIS_W-1:0]        axis_t;
    typedef logic signed [RATE_W-1:0] rate_t;
    typedef logic [DT_W-1:0]          dt_t;
    typedef logic [LANE_W-1:0]        gain_t;
    typedef logic [CREG_W-1:0]        creg_t;
    typedef logic [CIDX_W-1:0]        cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_PROP_GAINS   = 3'd0;
    localparam cfg_idx_t REG_INTEG_GAINS  = 3'd1;
    localparam cfg_idx_t REG_DERIV_GAINS  = 3'd2;
    localparam cfg_idx_t REG_FFWD_GAINS   = 3'd3;
    localparam cfg_idx_t REG_INTEG_LIMITS = 3'd4;

    // Picks the Q4.12 lane of one axis out of a packed register.
    function automatic gain_t lane_sel(input creg_t r, input axis_t a);
        gain_t g;
        case (a)
            2'd0:    g = r[0*LANE_W +: LANE_W];
            2'd1:    g = r[1*LANE_W +: LANE_W];
            2'd2:    g = r[2*LANE_W +: LANE_W];
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ src/rpid_sample_if.sv @@
interface rpid_sample_if;
    import rpid_pkg::*;

    logic  valid;
    logic  ready;
    axis_t axis;
    rate_t rate_meas;
    rate_t rate_setpoint;
    rate_t ang_accel;
    dt_t   step_time;
    logic  on_ground;
    logic  sat_pos;
    logic  sat_neg;

    modport source (
        output valid, axis, rate_meas, rate_setpoint, ang_accel,
               step_time, on_ground, sat_pos, sat_neg,
        input  ready
    );

    modport sink (
        input  valid, axis, rate_meas, rate_setpoint, ang_accel,
               step_time, on_ground, sat_pos, sat_neg,
        output ready
    );
endinterface

@@ src/rpid_result_if.sv @@
interface rpid_result_if;
    import rpid_pkg::*;

    logic  valid;
    logic  ready;
    axis_t out_axis;
    rate_t torque;
    rate_t integ_value;

    modport source (
        output valid, out_axis, torque, integ_value,
        input  ready
    );

    modport sink (
        input  valid, out_axis, torque, integ_value,
        output ready
    );
endinterface

@@ src/rate_pid_with_antiwindup_unit.sv @@
// Three-axis angular-rate PID controller with feedforward and integrator
// anti-windup, one axis per request. A request carries the measured rate,
// setpoint, angular acceleration, dt, a landed flag and the allocator
// saturation flags; the result carries the saturated Q16.16 torque
// kp*err + integ - kd*accel + kff*setpoint (using the integrator from before
// the request) and the integrator after the update. All arithmetic runs
// through one 33x24 signed multiplier under a small sequencer, so the block
// takes no new request until the last result is in the output register.
// An airborne request steps through the four multiplications of the torque
// and the square law, the reciprocal multiplication that divides the squared
// error by the squared rate limit together with the two products that check
// its estimate, and the three multiply-and-round stages of the increment. A
// landed request stops after the torque, and an axis index outside the
// configured axes goes straight to the output. A result that is not taken
// holds the sequencer in its last state. Gains must be written through the
// configuration port only while idle; the block does not enforce it.
module rate_pid_with_antiwindup_unit #(
    parameter int AXES       = 3,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  rpid_pkg::cfg_idx_t cfg_index,
    input  rpid_pkg::creg_t    cfg_wdata,
    rpid_sample_if.sink        sample,
    rpid_result_if.source      result
);
    import rpid_pkg::*;

    // Only three lanes exist in the packed registers.
    localparam int NUM_AX   = (AXES < NUM_LANES) ? AXES : NUM_LANES;
    localparam int AX_IDX_W = (NUM_AX > 1) ? $clog2(NUM_AX) : 1;
    localparam int RND_W    = SUM_W - TRQ_SH;
    localparam int CMP_W    = ((RND_W > DATA_WIDTH) ? RND_W : DATA_WIDTH) + 1;

    // Saturation bounds of a DATA_WIDTH-bit signed torque.
    localparam logic signed [CMP_W-1:0] SAT_HI =
        {{(CMP_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [CMP_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [4:0] {
        S_IDLE, S_KP, S_KD, S_KF, S_SQ, S_RND, S_EST, S_QLO, S_FAC, S_FK,
        S_R1, S_PM, S_R2, S_PD, S_R3, S_ADD, S_CLMP, S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    creg_t prop_gains_reg;
    creg_t integ_gains_reg;
    creg_t deriv_gains_reg;
    creg_t ffwd_gains_reg;
    creg_t integ_limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gains_reg   <= '0;
            integ_gains_reg  <= '0;
            deriv_gains_reg  <= '0;
            ffwd_gains_reg   <= '0;
            integ_limits_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PROP_GAINS:   prop_gains_reg   <= cfg_wdata;
                REG_INTEG_GAINS:  integ_gains_reg  <= cfg_wdata;
                REG_DERIV_GAINS:  deriv_gains_reg  <= cfg_wdata;
                REG_FFWD_GAINS:   ffwd_gains_reg   <= cfg_wdata;
                REG_INTEG_LIMITS: integ_limits_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers.
    // ------------------------------------------------------------------
    state_t                    state_reg,     state_next;
    axis_t                     axis_reg,      axis_next;
    rate_t                     sp_reg,        sp_next;
    rate_t                     accel_reg,     accel_next;
    dt_t                       dt_reg,        dt_next;
    logic                      landed_reg,    landed_next;
    logic                      spos_reg,      spos_next;
    logic                      sneg_reg,      sneg_next;
    logic signed [ERR_W-1:0]   err_reg,       err_next;
    logic [ERR_W-1:0]          mag_reg,       mag_next;
    logic                      eneg_reg,      eneg_next;
    logic                      big_reg,       big_next;
    logic signed [INTEG_W-1:0] integ_reg,     integ_next;
    logic signed [SUM_W-1:0]   acc_reg,       acc_next;
    logic signed [PROD_W-1:0]  prod_reg,      prod_next;
    logic [SCALE_W-1:0]        p_reg,         p_next;
    logic [MAG_SQ_W-1:0]       sq_reg,        sq_next;
    logic [QUO_W-1:0]          quo_reg,       quo_next;
    logic [QHI_W-1:0]          qhi_reg,       qhi_next;
    logic signed [UPD_W-1:0]   upd_reg,       upd_next;
    rate_t                     torque_reg,    torque_next;
    logic                      res_valid_reg, res_valid_next;
    axis_t                     res_axis_reg,  res_axis_next;
    rate_t                     res_torque_reg, res_torque_next;
    rate_t                     res_integ_reg, res_integ_next;

    // Integrator per axis, Q16.16 held in its clamped range.
    logic signed [INTEG_W-1:0] integ_mem [NUM_AX];

    // Gain lanes of the axis being served.
    gain_t kp_lane, ki_lane, kd_lane, kff_lane, lim_lane;

    assign kp_lane  = lane_sel(prop_gains_reg,   axis_reg);
    assign ki_lane  = lane_sel(integ_gains_reg,  axis_reg);
    assign kd_lane  = lane_sel(deriv_gains_reg,  axis_reg);
    assign kff_lane = lane_sel(ffwd_gains_reg,   axis_reg);
    assign lim_lane = lane_sel(integ_limits_reg, axis_reg);

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    logic                      in_range;
    logic                      req_take;
    logic                      res_load;

    // Error clipping by the allocator saturation flags.
    logic                      err_neg, err_pos, err_clip;

    // Torque rounding and saturation.
    logic signed [SUM_W-1:0]   acc_half;
    logic signed [RND_W-1:0]   trq_rnd;
    logic signed [CMP_W-1:0]   trq_ext;
    logic signed [CMP_W-1:0]   trq_sat;

    // Square-law division by reciprocal multiplication.
    logic [QUO_W-1:0]          quo_est;
    logic [QCMP_W-1:0]         qd_prod;
    logic [QCMP_W-1:0]         sq_scaled;
    logic                      quo_fits;
    logic [QUO_W-1:0]          quo_val;
    logic [QUO_W-1:0]          fac_val;

    // Round-half-up of the unsigned increment products.
    logic [RND_IN_W-1:0]       rnd_half;
    logic [RND_IN_W-1:0]       rnd_sum;

    // Integrator update and clamp.
    logic signed [UPD_W-1:0]   p_signed;
    logic signed [UPD_W-1:0]   integ_ext;
    logic signed [UPD_W-1:0]   lim_pos, lim_neg, upd_clamped;

    // ------------------------------------------------------------------
    // Shared multiplier. Each issuing state picks its operands; the
    // product is registered and consumed in the following state.
    // ------------------------------------------------------------------
    logic signed [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]              mul_b;
    logic signed [MUL_B_W:0]         mul_b_s;
    logic signed [MUL_A_W+MUL_B_W:0] mul_full;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_KP:
            begin
                mul_a = err_reg;
                mul_b = MUL_B_W'(kp_lane);
            end
            S_KD:
            begin
                mul_a = {accel_reg[RATE_W-1], accel_reg};
                mul_b = MUL_B_W'(kd_lane);
            end
            S_KF:
            begin
                mul_a = {sp_reg[RATE_W-1], sp_reg};
                mul_b = MUL_B_W'(kff_lane);
            end
            S_SQ:
            begin
                mul_a = MUL_A_W'(mag_reg[MAG_W-1:0]);
                mul_b = MUL_B_W'(mag_reg[MAG_W-1:0]);
            end
            S_RND:
            begin
                // The squared error sits in the product register here.
                mul_a = MUL_A_W'(prod_reg[MAG_SQ_W-1:SQ_DROP]);
                mul_b = RATE_LIMIT_SQ_RECIP;
            end
            S_EST:
            begin
                mul_a = MUL_A_W'(quo_est);
                mul_b = RATE_LIMIT_SQ_HI;
            end
            S_QLO:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = RATE_LIMIT_SQ_LO;
            end
            S_FK:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = MUL_B_W'(ki_lane);
            end
            S_PM:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = MUL_B_W'(mag_reg[MAG_W-1:0]);
            end
            S_PD:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_b_s  = {1'b0, mul_b};
    assign mul_full = mul_a * mul_b_s;

    assign in_range = ({1'b0, sample.axis} < 3'(NUM_AX));
    assign req_take = (state_reg == S_IDLE) && sample.valid;
    assign res_load = (state_reg == S_OUT) && (!res_valid_reg || result.ready);

    assign err_neg  = err_reg[ERR_W-1];
    assign err_pos  = !err_neg && (err_reg != '0);
    assign err_clip = (spos_reg && err_pos) || (sneg_reg && err_neg);

    // Adding half an LSB and shifting arithmetically floors toward minus
    // infinity, which gives round-half-up on the Q.28 sum.
    assign acc_half = acc_reg + SUM_W'(1 << (TRQ_SH - 1));
    assign trq_rnd  = acc_half[SUM_W-1:TRQ_SH];
    assign trq_ext  = {{(CMP_W - RND_W){trq_rnd[RND_W-1]}}, trq_rnd};
    assign trq_sat  = (trq_ext > SAT_HI) ? SAT_HI :
                      (trq_ext < SAT_LO) ? SAT_LO : trq_ext;

    // The reciprocal product never overshoots the true quotient and falls
    // short of it by at most one. The estimate plus one is kept and checked
    // against the squared error scaled to Q0.16; if it overshoots, the
    // quotient is one less. Whenever the factor is used the squared error
    // is below the squared limit, so the quotient fits in 16 bits.
    assign quo_est   = prod_reg[RECIP_SH +: QUO_W] + 1'b1;
    assign qd_prod   = {qhi_reg, {SQ_SPLIT{1'b0}}} + prod_reg[QCMP_W-1:0];
    assign sq_scaled = QCMP_W'({sq_reg, {FAC_FRAC_W{1'b0}}});
    assign quo_fits  = (qd_prod <= sq_scaled);
    assign quo_val   = quo_fits ? quo_reg : quo_reg - 1'b1;
    assign fac_val   = {1'b1, {FAC_FRAC_W{1'b0}}} - quo_val;

    always_comb
    begin
        case (state_reg)
            S_R1:    rnd_half = RND_IN_W'(1) << 11;
            S_R2:    rnd_half = RND_IN_W'(1) << 15;
            default: rnd_half = RND_IN_W'(1) << 23;
        endcase
    end

    assign rnd_sum = {1'b0, prod_reg[RND_IN_W-2:0]} + rnd_half;

    assign p_signed    = {1'b0, p_reg};
    assign integ_ext   = {{(UPD_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
    assign lim_pos     = UPD_W'({lim_lane, 4'b0000});
    assign lim_neg     = -lim_pos;
    assign upd_clamped = (upd_reg > lim_pos) ? lim_pos :
                         (upd_reg < lim_neg) ? lim_neg : upd_reg;

    // ------------------------------------------------------------------
    // Sequencer next-state logic.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        sp_next         = sp_reg;
        accel_next      = accel_reg;
        dt_next         = dt_reg;
        landed_next     = landed_reg;
        spos_next       = spos_reg;
        sneg_next       = sneg_reg;
        err_next        = err_reg;
        mag_next        = mag_reg;
        eneg_next       = eneg_reg;
        big_next        = big_reg;
        integ_next      = integ_reg;
        acc_next        = acc_reg;
        prod_next       = mul_full[PROD_W-1:0];
        p_next          = p_reg;
        sq_next         = sq_reg;
        quo_next        = quo_reg;
        qhi_next        = qhi_reg;
        upd_next        = upd_reg;
        torque_next     = torque_reg;
        res_axis_next   = res_axis_reg;
        res_torque_next = res_torque_reg;
        res_integ_next  = res_integ_reg;

        // A waiting result leaves when taken, unless replaced this cycle.
        res_valid_next  = res_valid_reg && !result.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    axis_next   = sample.axis;
                    sp_next     = sample.rate_setpoint;
                    accel_next  = sample.ang_accel;
                    dt_next     = sample.step_time;
                    landed_next = sample.on_ground;
                    spos_next   = sample.sat_pos;
                    sneg_next   = sample.sat_neg;
                    err_next    = {sample.rate_setpoint[RATE_W-1], sample.rate_setpoint}
                                - {sample.rate_meas[RATE_W-1], sample.rate_meas};
                    // An axis outside the configured set reports zeros.
                    torque_next = '0;
                    if (in_range)
                    begin
                        integ_next = integ_mem[sample.axis[AX_IDX_W-1:0]];
                        state_next = S_KP;
                    end
                    else
                    begin
                        integ_next = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_KP:
            begin
                eneg_next  = err_neg && !err_clip;
                if (err_clip)
                    mag_next = '0;
                else if (err_neg)
                    mag_next = -err_reg;
                else
                    mag_next = err_reg;
                state_next = S_KD;
            end
            S_KD:
            begin
                acc_next   = {{(SUM_W - INTEG_W - TRQ_SH){integ_reg[INTEG_W-1]}},
                              integ_reg, {TRQ_SH{1'b0}}} + prod_reg[SUM_W-1:0];
                big_next   = (mag_reg >= RATE_LIMIT);
                state_next = S_KF;
            end
            S_KF:
            begin
                acc_next   = acc_reg - prod_reg[SUM_W-1:0];
                state_next = S_SQ;
            end
            S_SQ:
            begin
                acc_next   = acc_reg + prod_reg[SUM_W-1:0];
                state_next = S_RND;
            end
            S_RND:
            begin
                torque_next = trq_sat[RATE_W-1:0];
                sq_next     = prod_reg[MAG_SQ_W-1:0];
                state_next  = landed_reg ? S_OUT : S_EST;
            end
            S_EST:
            begin
                quo_next   = quo_est;
                state_next = S_QLO;
            end
            S_QLO:
            begin
                qhi_next   = prod_reg[QHI_W-1:0];
                state_next = S_FAC;
            end
            S_FAC:
            begin
                // Integral factor in Q0.16: zero at or beyond the rate limit.
                p_next     = big_reg ? '0 : SCALE_W'(fac_val);
                state_next = S_FK;
            end
            S_FK:
            begin
                state_next = S_R1;
            end
            S_R1:
            begin
                p_next     = rnd_sum[12 +: SCALE_W];
                state_next = S_PM;
            end
            S_PM:
            begin
                state_next = S_R2;
            end
            S_R2:
            begin
                p_next     = rnd_sum[16 +: SCALE_W];
                state_next = S_PD;
            end
            S_PD:
            begin
                state_next = S_R3;
            end
            S_R3:
            begin
                p_next     = rnd_sum[24 +: SCALE_W];
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // The increment is built on magnitudes, then takes the sign
                // of the clipped error.
                upd_next   = integ_ext + (eneg_reg ? -p_signed : p_signed);
                state_next = S_CLMP;
            end
            S_CLMP:
            begin
                integ_next = upd_clamped[INTEG_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_load)
                begin
                    res_valid_next  = 1'b1;
                    res_axis_next   = axis_reg;
                    res_torque_next = torque_reg;
                    res_integ_next  = RATE_W'(integ_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= '0;
            sp_reg         <= '0;
            accel_reg      <= '0;
            dt_reg         <= '0;
            landed_reg     <= 1'b0;
            spos_reg       <= 1'b0;
            sneg_reg       <= 1'b0;
            err_reg        <= '0;
            mag_reg        <= '0;
            eneg_reg       <= 1'b0;
            big_reg        <= 1'b0;
            integ_reg      <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            p_reg          <= '0;
            sq_reg         <= '0;
            quo_reg        <= '0;
            qhi_reg        <= '0;
            upd_reg        <= '0;
            torque_reg     <= '0;
            res_valid_reg  <= 1'b0;
            res_axis_reg   <= '0;
            res_torque_reg <= '0;
            res_integ_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            sp_reg         <= sp_next;
            accel_reg      <= accel_next;
            dt_reg         <= dt_next;
            landed_reg     <= landed_next;
            spos_reg       <= spos_next;
            sneg_reg       <= sneg_next;
            err_reg        <= err_next;
            mag_reg        <= mag_next;
            eneg_reg       <= eneg_next;
            big_reg        <= big_next;
            integ_reg      <= integ_next;
            acc_reg        <= acc_next;
            prod_reg       <= prod_next;
            p_reg          <= p_next;
            sq_reg         <= sq_next;
            quo_reg        <= quo_next;
            qhi_reg        <= qhi_next;
            upd_reg        <= upd_next;
            torque_reg     <= torque_next;
            res_valid_reg  <= res_valid_next;
            res_axis_reg   <= res_axis_next;
            res_torque_reg <= res_torque_next;
            res_integ_reg  <= res_integ_next;
        end
    end

    // The clamped integrator is written back once per airborne request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AX; i++)
                integ_mem[i] <= '0;
        end
        else if (state_reg == S_CLMP)
        begin
            integ_mem[axis_reg[AX_IDX_W-1:0]] <= upd_clamped[INTEG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Channel outputs.
    // ------------------------------------------------------------------
    assign sample.ready       = (state_reg == S_IDLE);
    assign result.valid       = res_valid_reg;
    assign result.out_axis    = res_axis_reg;
    assign result.torque      = res_torque_reg;
    assign result.integ_value = res_integ_reg;

endmodule

@@ dv/rate_pid_with_antiwindup_unit_tb.sv @@
`timescale 1ns / 100ps

module rate_pid_with_antiwindup_unit_tb;
    import rpid_pkg::*;

    // Geometry of the block under test, kept equal to its parameters.
    localparam int NUM_AXES = 3;
    localparam int TRQ_BITS = 32;
    localparam int NUM_REGS = 5;

    // radians(400) in Q16.16: the error at which the integrator gain fades to zero.
    localparam longint RATE_FADE = 457528;

    // Traffic shaping. Each side idles at random, about IDLE_PCT percent of the time.
    localparam int IDLE_PCT       = 22;
    localparam int HOLD_CYCLES    = 500;
    localparam int HOLD_AFTER     = 300;
    localparam int CALM_FROM      = 600;
    localparam int CALM_TO        = 760;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 100;

    // One request as the sender offers it.
    typedef struct {
        axis_t axis;
        rate_t meas;
        rate_t setp;
        rate_t accel;
        dt_t   dt;
        logic  landed;
        logic  sat_hi;
        logic  sat_lo;
    } pid_req_t;

    // One result as the block should return it.
    typedef struct {
        axis_t axis;
        rate_t torque;
        rate_t integ;
    } pid_out_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_wr_en;
    cfg_idx_t cfg_index;
    creg_t    cfg_wdata;

    rpid_sample_if req_if ();
    rpid_result_if rsp_if ();

    rate_pid_with_antiwindup_unit #(
        .AXES       (NUM_AXES),
        .DATA_WIDTH (TRQ_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (req_if),
        .result    (rsp_if)
    );

    // Our own copy of the gain registers and of the three axis integrators.
    creg_t  gain_regs [NUM_REGS];
    longint integ_state [NUM_AXES];

    // Requests waiting to be offered, and results that the block still owes us.
    pid_req_t req_backlog[$];
    pid_out_t pending_results[$];

    int   n_err;
    int   n_results;
    int   stall_cycles;
    logic in_fire;
    int   hold_left;
    logic hold_done;

    // Both sides stop idling for a stretch so that back-to-back traffic is seen too.
    wire calm = (n_results >= CALM_FROM) && (n_results < CALM_TO);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pulls the Q4.12 lane of one axis out of a packed register.
    function automatic longint gain_of(input creg_t r, input int a);
        return longint'(r[a*LANE_W +: LANE_W]);
    endfunction

    // Computes the result of one request and advances the integrator of its axis.
    // The torque uses the integrator from before the request; the integrator is
    // then updated with the faded, saturation-clipped error unless landed.
    function automatic pid_out_t predict_axis_result(input pid_req_t r);
        pid_out_t        o;
        int              a;
        longint          err;
        longint          e;
        longint          acc_sum;
        longint          trq;
        longint          integ;
        longint          lim;
        longint unsigned mag;
        longint unsigned fac;
        longint unsigned inc;
        a = int'(r.axis);
        o.axis   = r.axis;
        o.torque = '0;
        o.integ  = '0;
        // An axis outside the configured set leaves every state alone.
        if (a >= NUM_AXES)
        begin
            return o;
        end

        err   = longint'(r.setp) - longint'(r.meas);
        integ = integ_state[a];

        // Torque is summed exactly in Q.28, rounded half up to Q16.16 and saturated.
        acc_sum = gain_of(gain_regs[REG_PROP_GAINS], a) * err + integ * 4096
                - gain_of(gain_regs[REG_DERIV_GAINS], a) * longint'(r.accel)
                + gain_of(gain_regs[REG_FFWD_GAINS], a) * longint'(r.setp);
        trq = (acc_sum + 2048) >>> 12;
        if (trq > 64'sd2147483647)
        begin
            trq = 64'sd2147483647;
        end
        else if (trq < -64'sd2147483648)
        begin
            trq = -64'sd2147483648;
        end

        if (!r.landed)
        begin
            // The allocator flags stop the error from pushing further into saturation.
            e = err;
            if (r.sat_hi && e > 0)
            begin
                e = 0;
            end
            if (r.sat_lo && e < 0)
            begin
                e = 0;
            end
            mag = longint'(e < 0 ? -e : e);

            // Square-law fade of the integral gain, Q0.16.
            if (mag >= RATE_FADE)
            begin
                fac = 0;
            end
            else
            begin
                fac = 65536 - (mag * mag * 65536) / (RATE_FADE * RATE_FADE);
            end

            // Increment on magnitudes, rounding half up at each stage.
            inc = (fac * gain_of(gain_regs[REG_INTEG_GAINS], a) + 2048) >> 12;
            inc = (inc * mag + 32768) >> 16;
            inc = (inc * longint'(r.dt) + (64'd1 << 23)) >> 24;
            integ = (e < 0) ? integ - longint'(inc) : integ + longint'(inc);

            // The limit lane is Q4.12; times 16 makes it Q16.16.
            lim = gain_of(gain_regs[REG_INTEG_LIMITS], a) * 16;
            if (integ > lim)
            begin
                integ = lim;
            end
            if (integ < -lim)
            begin
                integ = -lim;
            end
            integ_state[a] = integ;
        end

        o.torque = rate_t'(trq);
        o.integ  = rate_t'(integ_state[a]);
        return o;
    endfunction

    task automatic report(input string what, input longint want, input longint got);
        if (n_err < MAX_REPORTS)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
        n_err++;
    endtask

    // Writes one gain register at a falling edge and mirrors it in the predictor.
    task automatic write_reg(input cfg_idx_t idx, input creg_t val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        gain_regs[idx] = val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_gains(input creg_t kp, input creg_t ki, input creg_t kd,
                              input creg_t kff, input creg_t lim);
        write_reg(REG_PROP_GAINS, kp);
        write_reg(REG_INTEG_GAINS, ki);
        write_reg(REG_DERIV_GAINS, kd);
        write_reg(REG_FFWD_GAINS, kff);
        write_reg(REG_INTEG_LIMITS, lim);
    endtask

    task automatic queue_req(input axis_t axis, input rate_t meas, input rate_t setp,
                             input rate_t accel, input dt_t dt, input logic landed,
                             input logic sat_hi, input logic sat_lo);
        pid_req_t r;
        r.axis   = axis;
        r.meas   = meas;
        r.setp   = setp;
        r.accel  = accel;
        r.dt     = dt;
        r.landed = landed;
        r.sat_hi = sat_hi;
        r.sat_lo = sat_lo;
        req_backlog.push_back(r);
    endtask

    // Random request. Most are flight-like: moderate rates with an error of at
    // most 600000 either way, mostly below the fade limit, so the integrator
    // keeps moving and hits its clamps. Some sit right at the fade edge, and the
    // rest are raw noise over the full range of every field.
    function automatic pid_req_t rand_req();
        pid_req_t    r;
        int unsigned pick;
        longint      base;
        longint      delta;
        pick = $urandom_range(99);
        r.axis   = ($urandom_range(99) < 6) ? axis_t'(3) : axis_t'($urandom_range(2));
        r.dt     = dt_t'($urandom);
        r.landed = ($urandom_range(99) < 15);
        r.sat_hi = ($urandom_range(99) < 25);
        r.sat_lo = ($urandom_range(99) < 25);
        if (pick < 80)
        begin
            base = longint'($urandom_range(16777216)) - 8388608;
            if (pick < 68)
            begin
                delta = longint'($urandom_range(1200000)) - 600000;
            end
            else
            begin
                delta = RATE_FADE + longint'($urandom_range(8)) - 4;
                if ($urandom_range(1) == 0)
                begin
                    delta = -delta;
                end
            end
            r.meas  = rate_t'(base);
            r.setp  = rate_t'(base + delta);
            r.accel = rate_t'(longint'($urandom_range(4194304)) - 2097152);
        end
        else
        begin
            r.meas  = rate_t'($urandom);
            r.setp  = rate_t'($urandom);
            r.accel = rate_t'($urandom);
        end
        return r;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
        begin
            req_backlog.push_back(rand_req());
        end
    endtask

    // Returns once every queued request has been taken and every result checked.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_if.valid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Sender, acceptance side: a request is taken when valid and ready meet at a
    // rising edge. Its expected result is worked out right here, since the gains
    // only change while the block is idle.
    always @(posedge clk)
    begin : accept_proc
        pid_req_t cur;
        in_fire <= rst_n && req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            cur.axis   = req_if.axis;
            cur.meas   = req_if.rate_meas;
            cur.setp   = req_if.rate_setpoint;
            cur.accel  = req_if.ang_accel;
            cur.dt     = req_if.step_time;
            cur.landed = req_if.on_ground;
            cur.sat_hi = req_if.sat_pos;
            cur.sat_lo = req_if.sat_neg;
            pending_results.push_back(predict_axis_result(cur));
        end
    end

    // Sender, drive side: at the falling edge, once the current request is gone,
    // either present the next one or idle for a cycle. A request once offered
    // stays on the bus until it is taken.
    always @(negedge clk)
    begin : drive_proc
        pid_req_t nxt;
        if (rst_n && (!req_if.valid || in_fire))
        begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = req_backlog.pop_front();
                req_if.valid         <= 1'b1;
                req_if.axis          <= nxt.axis;
                req_if.rate_meas     <= nxt.meas;
                req_if.rate_setpoint <= nxt.setp;
                req_if.ang_accel     <= nxt.accel;
                req_if.step_time     <= nxt.dt;
                req_if.on_ground     <= nxt.landed;
                req_if.sat_pos       <= nxt.sat_hi;
                req_if.sat_neg       <= nxt.sat_lo;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off in the middle of a
    // busy phase. During the hold the sender keeps offering requests, so the
    // block has to stall its input while its result sits unclaimed.
    always @(negedge clk)
    begin : recv_proc
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (!hold_done && n_results >= HOLD_AFTER && req_backlog.size() > 30)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Checker: every result taken is compared field by field with the oldest
    // expectation.
    always @(posedge clk)
    begin : check_proc
        pid_out_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                if (n_err < MAX_REPORTS)
                begin
                    $display("%0t: result with nothing expected: axis %0d torque %0d integ %0d",
                             $time, rsp_if.out_axis, rsp_if.torque, rsp_if.integ_value);
                end
                n_err++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.out_axis !== want.axis)
                begin
                    report("out_axis", longint'(want.axis), longint'(rsp_if.out_axis));
                end
                if (rsp_if.torque !== want.torque)
                begin
                    report("torque", longint'(want.torque), longint'(rsp_if.torque));
                end
                if (rsp_if.integ_value !== want.integ)
                begin
                    report("integ_value", longint'(want.integ), longint'(rsp_if.integ_value));
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving means a hang.
    always @(posedge clk)
    begin : watchdog_proc
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stimulus_proc
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = REG_PROP_GAINS;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.axis          = '0;
        req_if.rate_meas     = '0;
        req_if.rate_setpoint = '0;
        req_if.ang_accel     = '0;
        req_if.step_time     = '0;
        req_if.on_ground     = 1'b0;
        req_if.sat_pos       = 1'b0;
        req_if.sat_neg       = 1'b0;
        rsp_if.ready         = 1'b0;
        in_fire              = 1'b0;
        hold_left            = 0;
        hold_done            = 1'b0;
        n_err                = 0;
        n_results            = 0;
        stall_cycles         = 0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            gain_regs[i] = '0;
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            integ_state[i] = 0;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Phase one: ordinary gains, different per axis, and the directed requests.
        load_gains(48'h2000_1000_0800, 48'h3000_1000_0400, 48'h0100_0080_0040,
                   48'h0400_0200_0100, 48'h0800_1000_0400);
        queue_req(2'd0, 0, 0, 0, 24'd0, 1'b0, 1'b0, 1'b0);
        // Largest positive and negative errors, with extreme acceleration.
        queue_req(2'd1, rate_t'(32'h8000_0000), rate_t'(32'h7FFF_FFFF),
                  rate_t'(32'h7FFF_FFFF), 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_req(2'd2, rate_t'(32'h7FFF_FFFF), rate_t'(32'h8000_0000),
                  rate_t'(32'h8000_0000), 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_req(2'd0, 0, 65536, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        // Saturation flags: one that does not apply, each one clipping, and both.
        queue_req(2'd0, 0, -65536, 0, 24'hFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_req(2'd0, 0, 65536, 0, 24'hFF_FFFF, 1'b0, 1'b1, 1'b0);
        queue_req(2'd1, 0, -65536, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b1);
        queue_req(2'd1, 0, 100000, 0, 24'hFF_FFFF, 1'b0, 1'b1, 1'b1);
        queue_req(2'd1, 0, -100000, 0, 24'hFF_FFFF, 1'b0, 1'b1, 1'b1);
        // Errors right at and just inside the fade limit, both signs.
        queue_req(2'd2, 0, 457528, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_req(2'd2, 0, 457527, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_req(2'd2, 457528, 0, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_req(2'd2, 457527, 0, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        // Landed: integrator frozen, torque still produced.
        queue_req(2'd0, 1000, -300000, 5000, 24'hFF_FFFF, 1'b1, 1'b0, 1'b0);
        // Axis index outside the configured set.
        queue_req(2'd3, rate_t'(32'h7FFF_FFFF), rate_t'(32'h8000_0000),
                  rate_t'(32'h7FFF_FFFF), 24'hFF_FFFF, 1'b1, 1'b1, 1'b1);
        queue_req(2'd3, 0, 0, 0, 24'd0, 1'b0, 1'b0, 1'b0);
        queue_req(2'd1, -200000, 200000, rate_t'(32'h8000_0000), 24'd1, 1'b0, 1'b0, 1'b0);
        queue_req(2'd1, -200000, 200000, 0, 24'd0, 1'b0, 1'b0, 1'b0);
        // Wind axis 0 up into its positive clamp, then back through to the negative one.
        repeat (3) queue_req(2'd0, 0, 300000, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        repeat (3) queue_req(2'd0, 0, -300000, 0, 24'hFF_FFFF, 1'b0, 1'b0, 1'b0);
        queue_random(120);
        wait_drained();

        // Phase two: every lane of every register at its maximum.
        load_gains(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                   48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_random(150);
        wait_drained();

        // Phase three: everything zero, so the integrators collapse onto a zero limit.
        load_gains('0, '0, '0, '0, '0);
        queue_random(100);
        wait_drained();

        // Remaining phases: random register contents.
        repeat (4)
        begin
            load_gains(creg_t'({$urandom, $urandom}), creg_t'({$urandom, $urandom}),
                       creg_t'({$urandom, $urandom}), creg_t'({$urandom, $urandom}),
                       creg_t'({$urandom, $urandom}));
            queue_random(160);
            wait_drained();
        end

        // Let a few more cycles pass so that a stray extra result would be caught.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_err == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
